@@ hw/rtl/scta_pkg.sv @@
`timescale 1ns / 1ps

package scta_pkg;

  localparam int FIFO_DEPTH = 512;
  localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 8;
  localparam int KEY_IDX_W  = 7;

  localparam logic [CODE_W-1:0] KEY_TABLE_LEN    = 8'd83;
  localparam logic [CODE_W-1:0] CODE_SHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] CODE_CAPS        = 8'h3A;
  localparam logic [CHAR_W-1:0] SHIFT_MARK       = 7'd5;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A       = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z       = 7'h7A;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // unshifted key map
  function automatic logic [CHAR_W-1:0] lower_char(input logic [KEY_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    case (idx)
      7'd1:  c = 7'd1;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h27;
      7'd13: c = 7'h3C;
      7'd14: c = 7'd8;
      7'd15: c = 7'd9;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5C;
      7'd27: c = 7'h2B;
      7'd28: c = 7'd10;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h7B;
      7'd41: c = 7'h7C;
      7'd42: c = SHIFT_MARK;
      7'd43: c = 7'h7D;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2D;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      7'd72: c = 7'd17;
      7'd75: c = 7'd18;
      7'd77: c = 7'd19;
      7'd80: c = 7'd20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // shifted key map
  function automatic logic [CHAR_W-1:0] upper_char(input logic [KEY_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    case (idx)
      7'd1:  c = 7'd1;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h22;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h26;
      7'd8:  c = 7'h2F;
      7'd9:  c = 7'h28;
      7'd10: c = 7'h29;
      7'd11: c = 7'h3D;
      7'd12: c = 7'h3F;
      7'd13: c = 7'h3E;
      7'd14: c = 7'd8;
      7'd15: c = 7'd9;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h5E;
      7'd27: c = 7'h2A;
      7'd28: c = 7'd10;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h7E;
      7'd40: c = 7'h5B;
      7'd41: c = 7'h2F;
      7'd42: c = SHIFT_MARK;
      7'd43: c = 7'h5D;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3B;
      7'd52: c = 7'h3A;
      7'd53: c = 7'h5F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      7'd72: c = 7'd17;
      7'd75: c = 7'd18;
      7'd77: c = 7'd19;
      7'd80: c = 7'd20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/scta_req_if.sv @@
`timescale 1ns / 1ps

interface scta_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [scta_pkg::CODE_W-1:0]  scancode;

  modport source (output valid, output action, output scancode, input ready);
  modport sink   (input valid, input action, input scancode, output ready);
endinterface

@@ hw/rtl/scta_chr_if.sv @@
`timescale 1ns / 1ps

interface scta_chr_if;
  logic                         valid;
  logic                         ready;
  logic [scta_pkg::CHAR_W-1:0]  char_out;
  logic                         was_empty;

  modport source (output valid, output char_out, output was_empty, input ready);
  modport sink   (input valid, input char_out, input was_empty, output ready);
endinterface

@@ hw/rtl/scancode_to_ascii_fifo_core.sv @@
// pipeline: a read of a non-empty buffer passes the synchronous ram read and then the
//   output register before its character shows
// stalls: no request is taken while a ram read is in flight, so a read of a non-empty
//   buffer holds off the next request; a read of an empty buffer starts no ram read
// reset: synchronous, active high; clears pointers, count, shift and caps flags, output valid
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_core (
  input  logic       clk,
  input  logic       rst,
  scta_req_if.sink   req,
  scta_chr_if.source chr
);

  // ---------------------------------------------------------------------
  // control and flag registers
  // ---------------------------------------------------------------------
  logic [scta_pkg::PTR_W-1:0]  read_ptr;
  logic [scta_pkg::PTR_W-1:0]  write_ptr;
  logic [scta_pkg::CNT_W-1:0]  fill_count;
  logic                        shift_held;
  logic                        caps_on;
  logic                        rd_pending;   // ram read in flight, data lands next cycle

  // output register
  logic                        out_valid;
  logic [scta_pkg::CHAR_W-1:0] out_char;
  logic                        out_empty;

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  // a read needs the output slot free by the time its result lands; scancodes
  // never produce a result, so they only wait out a read in flight
  logic out_free;
  logic req_fire;
  logic out_fire;

  assign out_free  = !out_valid || chr.ready;
  assign req.ready = !rd_pending && (out_free || req.action == scta_pkg::ACT_KEY);
  assign req_fire  = req.valid && req.ready;
  assign out_fire  = out_valid && chr.ready;

  assign chr.valid     = out_valid;
  assign chr.char_out  = out_char;
  assign chr.was_empty = out_empty;

  // ---------------------------------------------------------------------
  // scancode decode and translation
  // ---------------------------------------------------------------------
  logic                           fifo_full;
  logic                           fifo_empty;
  logic                           code_legal;
  logic                           is_break;
  logic                           is_caps;
  logic [scta_pkg::KEY_IDX_W-1:0] key_idx;
  logic [scta_pkg::CHAR_W-1:0]    lo_char;
  logic [scta_pkg::CHAR_W-1:0]    up_char;
  logic                           is_shift_make;
  logic                           is_letter;
  logic                           use_upper;
  logic [scta_pkg::CHAR_W-1:0]    xlat_char;

  assign fifo_full  = fill_count == scta_pkg::CNT_W'(scta_pkg::FIFO_DEPTH);
  assign fifo_empty = fill_count == '0;

  assign is_break   = req.scancode == scta_pkg::CODE_SHIFT_BREAK;
  assign is_caps    = req.scancode == scta_pkg::CODE_CAPS;
  assign code_legal = (req.scancode < scta_pkg::KEY_TABLE_LEN) || is_break || is_caps;

  // legal table codes are all below 128
  assign key_idx = req.scancode[scta_pkg::KEY_IDX_W-1:0];
  assign lo_char = scta_pkg::lower_char(key_idx);
  assign up_char = scta_pkg::upper_char(key_idx);

  assign is_shift_make = lo_char == scta_pkg::SHIFT_MARK;
  assign is_letter     = (lo_char >= scta_pkg::CHAR_LOW_A) && (lo_char <= scta_pkg::CHAR_LOW_Z);
  // letters follow shift xor caps lock, everything else follows shift only
  assign use_upper     = is_letter ? (shift_held ^ caps_on) : shift_held;
  assign xlat_char     = use_upper ? up_char : lo_char;

  // a scancode that takes effect; when the buffer is full it is dropped whole,
  // modifier keys included
  logic key_take;
  logic do_push;
  logic do_pop;
  logic do_empty_read;

  assign key_take      = req_fire && (req.action == scta_pkg::ACT_KEY) && code_legal
                         && !fifo_full;
  assign do_push       = key_take && !is_break && !is_caps && !is_shift_make;
  assign do_pop        = req_fire && (req.action == scta_pkg::ACT_READ) && !fifo_empty;
  assign do_empty_read = req_fire && (req.action == scta_pkg::ACT_READ) && fifo_empty;

  // ---------------------------------------------------------------------
  // character ram
  // ---------------------------------------------------------------------
  // a pop only addresses entries counted in fill_count, all written on earlier
  // edges, and one request per cycle keeps a push and a pop apart, so no
  // forwarding path is needed
  logic [scta_pkg::CHAR_W-1:0] ram_rdata;

  scta_ram #(
    .DEPTH (scta_pkg::FIFO_DEPTH),
    .WIDTH (scta_pkg::CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (write_ptr),
    .wdata (xlat_char),
    .re    (do_pop),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // pointer and count update
  // ---------------------------------------------------------------------
  logic [scta_pkg::PTR_W-1:0] read_ptr_next;
  logic [scta_pkg::PTR_W-1:0] write_ptr_next;

  // wrap at the buffer depth, which need not be a power of two
  assign read_ptr_next  = (read_ptr == scta_pkg::PTR_W'(scta_pkg::FIFO_DEPTH - 1))
                          ? '0 : read_ptr + 1'b1;
  assign write_ptr_next = (write_ptr == scta_pkg::PTR_W'(scta_pkg::FIFO_DEPTH - 1))
                          ? '0 : write_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr   <= '0;
      write_ptr  <= '0;
      fill_count <= '0;
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= do_pop;
      if (do_push) begin
        write_ptr  <= write_ptr_next;
        fill_count <= fill_count + 1'b1;
      end
      if (do_pop) begin
        read_ptr   <= read_ptr_next;
        fill_count <= fill_count - 1'b1;
      end
      if (key_take && is_break) begin
        shift_held <= 1'b0;
      end
      if (key_take && is_caps) begin
        caps_on <= !caps_on;
      end
      // a repeated shift make just keeps the flag set and pushes nothing
      if (key_take && !is_break && !is_caps && is_shift_make) begin
        shift_held <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pending || do_empty_read) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_char  <= ram_rdata;
      out_empty <= 1'b0;
    end else if (do_empty_read) begin
      out_char  <= '0;
      out_empty <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/scta_ram.sv @@
`timescale 1ns / 1ps

module scta_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 7
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
